/* sv/whik_pkg.sv */
// Shared types, widths and constants of the weighted histogram intersection block.
// Used by every module of the block; depends on nothing.
`default_nettype none

package whik_pkg;

   localparam int BINS_PER_REGION = 250;
   localparam int REGION_COUNT    = 9;
   localparam int TOTAL_BINS      = BINS_PER_REGION * REGION_COUNT;

   localparam int BIN_W    = 16;
   localparam int WEIGHT_W = 16;
   localparam int PROD_W   = BIN_W + WEIGHT_W;
   localparam int ACC_W    = 48;
   localparam int FRAC_W   = 16;
   localparam int SCORE_W  = 20;
   localparam int POS_W    = $clog2(TOTAL_BINS);
   localparam int IDX_W    = $clog2(BINS_PER_REGION + 1);
   localparam int REGION_W = 4;

   typedef logic [BIN_W-1:0]    bin_type;
   typedef logic [WEIGHT_W-1:0] weight_type;
   typedef logic [PROD_W-1:0]   prod_type;
   typedef logic [ACC_W-1:0]    acc_type;
   typedef logic [SCORE_W-1:0]  score_type;
   typedef logic [POS_W-1:0]    pos_type;
   typedef logic [IDX_W-1:0]    idx_type;
   typedef logic [REGION_W-1:0] region_type;

   localparam idx_type    IDX_LAST    = idx_type'(BINS_PER_REGION - 1);
   localparam region_type REGION_LAST = region_type'(REGION_COUNT - 1);

   // Grid positions, row-major from the top left.
   localparam region_type REGION_TOP    = 4'd1;
   localparam region_type REGION_LEFT   = 4'd3;
   localparam region_type REGION_CENTRE = 4'd4;
   localparam region_type REGION_RIGHT  = 4'd5;
   localparam region_type REGION_BOTTOM = 4'd7;

   // Region weights in Q0.16, truncated.
   localparam weight_type WEIGHT_CORNER = 16'd4915;
   localparam weight_type WEIGHT_EDGE   = 16'd8192;
   localparam weight_type WEIGHT_CENTRE = 16'd13107;

   localparam score_type SCORE_MAX       = {SCORE_W{1'b1}};
   localparam score_type THRESHOLD_RESET = 20'd32768;

   // Control that travels with one bin down the pipeline.
   typedef struct packed {
      logic       valid;
      logic       load;     // first frame of a sequence: store only
      logic       result;   // last bin of a compared frame
      logic       clear;    // new sequence starts with this bin
      region_type region;
   } stage_ctrl_type;

   typedef struct packed {
      logic      keep_current;
      logic      keep_previous;
      score_type score;
   } result_type;

   function automatic weight_type region_weight(input region_type region);
      weight_type w;
      case (region)
         REGION_CENTRE: w = WEIGHT_CENTRE;
         REGION_TOP:    w = WEIGHT_EDGE;
         REGION_LEFT:   w = WEIGHT_EDGE;
         REGION_RIGHT:  w = WEIGHT_EDGE;
         REGION_BOTTOM: w = WEIGHT_EDGE;
         default:       w = WEIGHT_CORNER;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

/* sv/whik_bin_store.sv */
// Previous-frame bin store: one synchronous read-first port with registered read data.
// Depends on whik_pkg for widths and depth.
`default_nettype none

module whik_bin_store (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire whik_pkg::pos_type addr,
   input  wire whik_pkg::bin_type wdata,
   output whik_pkg::bin_type      rdata
);

   whik_pkg::bin_type mem [whik_pkg::TOTAL_BINS];
   whik_pkg::bin_type rdata_ff;

   // Return the old entry and replace it with the new bin in the same cycle.
   always_ff @(posedge clock) begin
      if (en) begin
         rdata_ff  <= mem[addr];
         mem[addr] <= wdata;
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* sv/whik_score.sv */
// Intersection datapath: min and weight multiply, 48-bit accumulate, score and flags.
// Depends on whik_pkg for types, weights and the control struct.
`default_nettype none

module whik_score (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire whik_pkg::stage_ctrl_type s1_ctrl,
   input  wire whik_pkg::bin_type        s1_bin,
   input  wire whik_pkg::bin_type        stored_bin,
   input  wire whik_pkg::score_type      threshold,
   output logic                          result_pending,
   output logic                          res_valid,
   output whik_pkg::result_type          res_data
);

   whik_pkg::stage_ctrl_type s2_ctrl_ff, s2_ctrl_in;
   whik_pkg::prod_type       prod_ff, prod_in;
   whik_pkg::bin_type        smaller;
   whik_pkg::acc_type        acc_ff, acc_in, acc_base, acc_sum;
   whik_pkg::acc_type        final_ff, final_in;
   logic                     s3_result_ff, s3_result_in;
   logic                     s3_clear_ff, s3_clear_in;
   logic                     prev_similar_ff, prev_similar_in;
   whik_pkg::score_type      score;
   logic                     similar;

   // Stage 1: smaller bin times region weight.
   always_comb begin
      smaller    = (stored_bin < s1_bin) ? stored_bin : s1_bin;
      prod_in    = whik_pkg::prod_type'(smaller) *
                   whik_pkg::prod_type'(whik_pkg::region_weight(s1_ctrl.region));
      s2_ctrl_in = s1_ctrl;
   end

   // Stage 2: accumulate; restart on a new sequence, empty after a compared frame.
   always_comb begin
      acc_base     = s2_ctrl_ff.clear ? '0 : acc_ff;
      acc_sum      = s2_ctrl_ff.load ? acc_base : acc_base + whik_pkg::acc_type'(prod_ff);
      acc_in       = acc_ff;
      final_in     = final_ff;
      s3_result_in = s2_ctrl_ff.valid & s2_ctrl_ff.result;
      s3_clear_in  = s2_ctrl_ff.valid & s2_ctrl_ff.clear;
      if (s2_ctrl_ff.valid) begin
         acc_in = s2_ctrl_ff.result ? '0 : acc_sum;
         if (s2_ctrl_ff.result) begin
            final_in = acc_sum;
         end
      end
   end

   // Stage 3: take the integer part as an unsigned Q20.0 score, saturate, compare.
   always_comb begin
      if (|final_ff[whik_pkg::ACC_W-1:whik_pkg::FRAC_W+whik_pkg::SCORE_W]) begin
         score = whik_pkg::SCORE_MAX;
      end else begin
         score = final_ff[whik_pkg::FRAC_W+whik_pkg::SCORE_W-1:whik_pkg::FRAC_W];
      end
      similar = score < threshold;
      prev_similar_in = prev_similar_ff;
      if (s3_clear_ff) begin
         prev_similar_in = 1'b0;
      end else if (s3_result_ff) begin
         prev_similar_in = similar;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctrl_ff      <= '0;
         acc_ff          <= '0;
         s3_result_ff    <= 1'b0;
         s3_clear_ff     <= 1'b0;
         prev_similar_ff <= 1'b0;
      end else begin
         s2_ctrl_ff      <= s2_ctrl_in;
         acc_ff          <= acc_in;
         s3_result_ff    <= s3_result_in;
         s3_clear_ff     <= s3_clear_in;
         prev_similar_ff <= prev_similar_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      final_ff <= final_in;
   end

   assign result_pending         = (s2_ctrl_ff.valid & s2_ctrl_ff.result) | s3_result_ff;
   assign res_valid              = s3_result_ff;
   assign res_data.score         = score;
   assign res_data.keep_previous = similar & ~prev_similar_ff;
   assign res_data.keep_current  = similar;

endmodule

`default_nettype wire

/* sv/whik_out_queue.sv */
// Two-entry result queue that decouples the datapath from the rsp stream.
// Depends on whik_pkg for the result struct.
`default_nettype none

module whik_out_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire whik_pkg::result_type push_data,
   output logic                      pop_valid,
   input  wire logic                 pop_ready,
   output whik_pkg::result_type      pop_data,
   output logic [1:0]                level
);

   whik_pkg::result_type entry_ff [2];
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           count_ff, count_in;
   logic                 pop;

   always_comb begin
      pop       = pop_valid & pop_ready;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_valid = count_ff != 2'd0;
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign level     = count_ff;

endmodule

`default_nettype wire

/* sv/weighted_histogram_intersection_keyframe.sv */
// Weighted 3x3 histogram intersection key-frame detector, top level.
// Depends on whik_pkg, whik_bin_store, whik_score and whik_out_queue.
//
// Use:
//   req stream: one histogram bin per beat, 9 regions of 250 bins each, row-major
//     region order. tuser high on a beat restarts a sequence; that beat is bin 0
//     of a loading frame. The first frame after reset or a restart only fills
//     the bin store and yields no rsp beat.
//   rsp stream: one beat at the last bin of every compared frame: score (Q20.0,
//     saturating) and the two key-frame flags.
//   csr: csr_we writes the similarity threshold (Q20.0); write it while idle.
// Throughput: one bin per cycle while req_tready is high, set by the single read-first
//   port of the bin store, which reads the old bin and writes the new one in the same
//   cycle. The last bin of a frame is registered with the store read, then passes
//   the multiply, accumulate and score stages into the queue that holds the rsp beat.
// Reset: position, accumulator and flags clear, the threshold returns to 32768 and
//   the next frame loads. The store itself is not cleared: every compare follows a
//   full load.
// Stall: results wait in a two-entry queue; req_tready drops while the queue is full,
//   or holds one result while another is in flight, so bins flow past one waiting beat.
`default_nettype none

module weighted_histogram_intersection_keyframe (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] bin_value
   input  wire logic        req_tuser,   // [0] new_sequence
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [19:0] score, [20] keep_previous,
                                         // [21] keep_current, [23:22] zero
   input  wire logic        csr_we,
   input  wire logic [19:0] csr_wdata    // [19:0] similarity_threshold
);

   logic                     accept;
   logic                     new_seq;
   logic                     loading_now;
   logic                     last_bin;
   whik_pkg::pos_type        pos_cur, pos_ff, pos_in;
   whik_pkg::idx_type        idx_cur, idx_ff, idx_in;
   whik_pkg::region_type     region_cur, region_ff, region_in;
   logic                     loading_ff, loading_in;
   whik_pkg::score_type      threshold_ff, threshold_in;
   whik_pkg::stage_ctrl_type s1_ctrl_ff, s1_ctrl_in;
   whik_pkg::bin_type        s1_bin_ff;
   whik_pkg::bin_type        stored_bin;
   logic                     result_pending;
   logic                     res_valid;
   whik_pkg::result_type     res_data;
   whik_pkg::result_type     out_data;
   logic [1:0]               level;

   // Hold off bins while the queue is full, or holds one result with another in flight.
   assign req_tready = (level == 2'd0) |
                       ((level == 2'd1) & ~s1_ctrl_ff.result & ~result_pending);
   assign accept     = req_tvalid & req_tready;
   assign new_seq    = req_tuser;

   // Bin position: a restart takes effect on its own beat.
   always_comb begin
      pos_cur     = new_seq ? '0 : pos_ff;
      idx_cur     = new_seq ? '0 : idx_ff;
      region_cur  = new_seq ? '0 : region_ff;
      loading_now = new_seq | loading_ff;
      last_bin    = (region_cur == whik_pkg::REGION_LAST) & (idx_cur == whik_pkg::IDX_LAST);

      pos_in     = pos_ff;
      idx_in     = idx_ff;
      region_in  = region_ff;
      loading_in = loading_ff;
      if (accept) begin
         if (last_bin) begin
            pos_in     = '0;
            idx_in     = '0;
            region_in  = '0;
            loading_in = 1'b0;
         end else begin
            pos_in     = pos_cur + whik_pkg::pos_type'(1);
            loading_in = loading_now;
            if (idx_cur == whik_pkg::IDX_LAST) begin
               idx_in    = '0;
               region_in = region_cur + whik_pkg::region_type'(1);
            end else begin
               idx_in    = idx_cur + whik_pkg::idx_type'(1);
               region_in = region_cur;
            end
         end
      end

      s1_ctrl_in.valid  = accept;
      s1_ctrl_in.load   = loading_now;
      s1_ctrl_in.result = accept & last_bin & ~loading_now;
      s1_ctrl_in.clear  = new_seq;
      s1_ctrl_in.region = region_cur;

      threshold_in = csr_we ? csr_wdata : threshold_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         idx_ff       <= '0;
         region_ff    <= '0;
         loading_ff   <= 1'b1;
         threshold_ff <= whik_pkg::THRESHOLD_RESET;
         s1_ctrl_ff   <= '0;
      end else begin
         pos_ff       <= pos_in;
         idx_ff       <= idx_in;
         region_ff    <= region_in;
         loading_ff   <= loading_in;
         threshold_ff <= threshold_in;
         s1_ctrl_ff   <= s1_ctrl_in;
      end
   end

   // Advance the bin alongside the store read.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_bin_ff <= req_tdata;
      end
   end

   whik_bin_store u_store (
      .clock (clock),
      .en    (accept),
      .addr  (pos_cur),
      .wdata (req_tdata),
      .rdata (stored_bin)
   );

   whik_score u_score (
      .clock          (clock),
      .reset          (reset),
      .s1_ctrl        (s1_ctrl_ff),
      .s1_bin         (s1_bin_ff),
      .stored_bin     (stored_bin),
      .threshold      (threshold_ff),
      .result_pending (result_pending),
      .res_valid      (res_valid),
      .res_data       (res_data)
   );

   whik_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res_data),
      .pop_valid (rsp_tvalid),
      .pop_ready (rsp_tready),
      .pop_data  (out_data),
      .level     (level)
   );

   assign rsp_tdata = {2'b00, out_data.keep_current, out_data.keep_previous, out_data.score};

endmodule

`default_nettype wire

/* tb/whik_keyframe_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the weighted 3x3 histogram intersection key-frame block.
// Predicts every rsp beat from the req and csr traffic and checks it field by field.
// Depends on whik_pkg for the frame geometry.

module whik_keyframe_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,    // [15:0] bin_value
   input  logic        req_tuser,    // [0] new_sequence
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,    // [19:0] score, [20] keep_previous, [21] keep_current
   input  logic        csr_we,
   input  logic [19:0] csr_wdata,    // [19:0] similarity_threshold
   output int          mismatch_count,
   output int          verdicts_outstanding
);

   localparam int FRAME_BINS  = whik_pkg::TOTAL_BINS;
   localparam int REGION_BINS = whik_pkg::BINS_PER_REGION;

   // Q0.16 region weights, truncated
   localparam logic [15:0] W_CORNER = 16'd4915;
   localparam logic [15:0] W_EDGE   = 16'd8192;
   localparam logic [15:0] W_CENTRE = 16'd13107;

   localparam logic [19:0] SCORE_CEILING      = 20'hFFFFF;
   localparam logic [19:0] THRESHOLD_AT_RESET = 20'd32768;

   typedef struct packed {
      logic        keep_current;
      logic        keep_previous;
      logic [19:0] score;
   } keyframe_verdict_type;

   logic [15:0]          prior_bins [FRAME_BINS];
   int unsigned          bin_slot;
   logic [47:0]          overlap_sum;
   logic                 prior_similar;
   logic                 loading_frame;
   logic [19:0]          threshold;
   keyframe_verdict_type verdicts_due [$];

   function automatic logic [15:0] weight_of(input int unsigned region);
      int unsigned row;
      int unsigned col;
      row = region / 3;
      col = region % 3;
      if (row == 1 && col == 1) return W_CENTRE;
      if (row == 1 || col == 1) return W_EDGE;
      return W_CORNER;
   endfunction

   // Fold one bin into the running intersection; queue a verdict at the end of a
   // compared frame.
   task automatic take_bin(input logic [15:0] bin_in, input logic restart);
      logic [15:0]          lesser;
      logic [31:0]          coarse;
      logic [19:0]          score;
      logic                 similar;
      keyframe_verdict_type verdict;
      if (restart) begin
         bin_slot      = 0;
         overlap_sum   = '0;
         prior_similar = 1'b0;
         loading_frame = 1'b1;
      end
      if (!loading_frame) begin
         lesser      = (prior_bins[bin_slot] < bin_in) ? prior_bins[bin_slot] : bin_in;
         overlap_sum = overlap_sum + 48'(lesser) * 48'(weight_of(bin_slot / REGION_BINS));
      end
      prior_bins[bin_slot] = bin_in;
      if (bin_slot + 1 < FRAME_BINS) begin
         bin_slot = bin_slot + 1;
      end else begin
         bin_slot = 0;
         if (loading_frame) begin
            loading_frame = 1'b0;
         end else begin
            coarse  = overlap_sum[47:16];
            score   = (coarse > 32'(SCORE_CEILING)) ? SCORE_CEILING : coarse[19:0];
            similar = score < threshold;
            verdict.keep_current  = similar;
            verdict.keep_previous = similar && !prior_similar;
            verdict.score         = score;
            verdicts_due.insert(verdicts_due.size(), verdict);
            prior_similar = similar;
         end
         overlap_sum = '0;
      end
   endtask

   always @(posedge clock) begin : watch
      keyframe_verdict_type due;
      if (reset) begin
         bin_slot       = 0;
         overlap_sum    = '0;
         prior_similar  = 1'b0;
         loading_frame  = 1'b1;
         threshold      = THRESHOLD_AT_RESET;
         mismatch_count = 0;
         verdicts_due.delete();
      end else begin
         if (csr_we) threshold = csr_wdata;
         if (rsp_tvalid && rsp_tready) begin
            if (verdicts_due.size() == 0) begin
               $error("rsp beat with no result due: tdata %h", rsp_tdata);
               mismatch_count++;
            end else begin
               due = verdicts_due.pop_front();
               if (rsp_tdata[19:0] !== due.score) begin
                  $error("score: expected %0d, actual %0d", due.score, rsp_tdata[19:0]);
                  mismatch_count++;
               end
               if (rsp_tdata[20] !== due.keep_previous) begin
                  $error("keep_previous: expected %b, actual %b",
                         due.keep_previous, rsp_tdata[20]);
                  mismatch_count++;
               end
               if (rsp_tdata[21] !== due.keep_current) begin
                  $error("keep_current: expected %b, actual %b",
                         due.keep_current, rsp_tdata[21]);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) take_bin(req_tdata, req_tuser);
      end
      verdicts_outstanding <= verdicts_due.size();
   end

endmodule

/* tb/tb_weighted_histogram_intersection_keyframe.sv */
`timescale 1ns / 1ps
// Testbench top for the weighted 3x3 histogram intersection key-frame block.
// Drives whole frames of bins and threshold writes; whik_keyframe_checker scores the rsp beats.

module tb_weighted_histogram_intersection_keyframe;

   localparam int FRAME_BINS     = whik_pkg::TOTAL_BINS;
   localparam int REGION_BINS    = whik_pkg::BINS_PER_REGION;
   localparam int IDLE_PERCENT   = 13;
   localparam int DRAIN_CYCLES   = 8;       // margin for the pipeline to drain
   localparam int HOLD_CYCLES    = 12000;   // long enough to fill the result queue
   localparam int WATCHDOG_LIMIT = 40000;
   localparam int RESULT_TARGET  = 40;

   localparam logic [19:0] THRESHOLD_TOP = 20'hFFFFF;
   localparam logic [15:0] BIN_FULL      = 16'hFFFF;
   // An edge region weighs exactly 1/8, so one edge bin of 8*s scores exactly s.
   localparam logic [19:0] PROBE_SCORE   = 20'd1000;
   localparam logic [15:0] PROBE_BIN     = 16'd8000;

   typedef enum logic [1:0] {
      FRAME_FILL,     // every bin the same level
      FRAME_SPARSE,   // first bin of the top edge region only
      FRAME_SPREAD    // uniform random bins up to the level
   } frame_shape_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;    // [15:0] bin_value
   logic        req_tuser;    // [0] new_sequence
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;    // [19:0] score, [20] keep_previous, [21] keep_current
   logic        csr_we;
   logic [19:0] csr_wdata;    // [19:0] similarity_threshold

   int mismatch_count;
   int verdicts_outstanding;
   int results_seen;
   int quiet_cycles;
   bit calm;            // no idling on either side while set
   bit hold_request;    // ask the receiver for one long hold-off

   weighted_histogram_intersection_keyframe i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   whik_keyframe_checker i_scoreboard (
      .clock                (clock),
      .reset                (reset),
      .req_tvalid           (req_tvalid),
      .req_tready           (req_tready),
      .req_tdata            (req_tdata),
      .req_tuser            (req_tuser),
      .rsp_tvalid           (rsp_tvalid),
      .rsp_tready           (rsp_tready),
      .rsp_tdata            (rsp_tdata),
      .csr_we               (csr_we),
      .csr_wdata            (csr_wdata),
      .mismatch_count       (mismatch_count),
      .verdicts_outstanding (verdicts_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Offer one bin beat and hold it until the block takes it. Insert a short
   // random gap first unless the calm stretch is on.
   task automatic push_bin(input logic [15:0] value, input logic restart);
      if (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= restart;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Send the first `length` bins of a frame; a frame cut short is followed by
   // a restart from the caller.
   task automatic send_frame(input frame_shape_type shape, input logic [15:0] level,
                             input logic restart, input int unsigned length);
      logic [15:0] value;
      for (int unsigned i = 0; i < length; i++) begin
         case (shape)
            FRAME_FILL:   value = level;
            FRAME_SPARSE: value = (i == REGION_BINS) ? level : 16'd0;
            default:      value = 16'($urandom_range(0, level));
         endcase
         push_bin(value, restart && i == 0);
      end
   endtask

   // Drop valid and wait until every predicted verdict has come out, then let
   // the pipeline drain bins that carry no result.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);   // let the scoreboard count the last beat
      while (verdicts_outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Change the threshold only with the block idle.
   task automatic write_threshold(input logic [19:0] value);
      settle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin : stimulus
      int unsigned     frames;
      int unsigned     cut;
      logic [15:0]     level;
      frame_shape_type shape;
      bit              restart_next;
      int              phase;

      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = 1'b0;
      csr_we       = 1'b0;
      csr_wdata    = '0;
      calm         = 1'b0;
      hold_request = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed frames.
      // First frame after reset loads the store even without new_sequence.
      send_frame(FRAME_FILL, BIN_FULL, 1'b0, FRAME_BINS);
      // Full overlap saturates the score, far above the reset threshold.
      send_frame(FRAME_FILL, BIN_FULL, 1'b0, FRAME_BINS);
      // Saturated score equal to the top threshold: strict compare, not similar.
      write_threshold(THRESHOLD_TOP);
      send_frame(FRAME_FILL, BIN_FULL, 1'b0, FRAME_BINS);
      // Zero overlap: similar, previous newly kept; then again, previous already kept.
      send_frame(FRAME_FILL, 16'd0, 1'b0, FRAME_BINS);
      send_frame(FRAME_FILL, BIN_FULL, 1'b0, FRAME_BINS);
      // Exact probe score against zero, equal and one-above thresholds.
      write_threshold('0);
      send_frame(FRAME_SPARSE, PROBE_BIN, 1'b0, FRAME_BINS);
      write_threshold(PROBE_SCORE);
      send_frame(FRAME_SPARSE, PROBE_BIN, 1'b0, FRAME_BINS);
      write_threshold(PROBE_SCORE + 20'd1);
      send_frame(FRAME_SPARSE, PROBE_BIN, 1'b0, FRAME_BINS);
      // New sequence mid-frame, then again on the last bin position of a load.
      send_frame(FRAME_SPREAD, 16'd700, 1'b0, 1000);
      send_frame(FRAME_SPREAD, 16'd700, 1'b1, FRAME_BINS - 1);
      send_frame(FRAME_SPREAD, 16'd700, 1'b1, FRAME_BINS);
      send_frame(FRAME_SPREAD, 16'd700, 1'b0, FRAME_BINS);

      // Random phases: a threshold per phase, then a few frames. Low levels keep
      // scores near the threshold; full-range frames exercise every bin bit.
      restart_next = 1'b0;
      phase        = 0;
      while (results_seen < RESULT_TARGET) begin
         case ($urandom_range(9))
            0:       write_threshold('0);
            1:       write_threshold(THRESHOLD_TOP);
            default: write_threshold(20'($urandom_range(0, 150000)));
         endcase
         calm = (phase == 3);
         if (phase == 1) hold_request = 1'b1;
         frames = (phase == 1) ? 5 : $urandom_range(2, 5);
         repeat (frames) begin
            cut = ($urandom_range(99) < 6) ? $urandom_range(1, FRAME_BINS - 1) : FRAME_BINS;
            case ($urandom_range(7))
               0: begin
                  shape = FRAME_SPREAD;
                  level = BIN_FULL;
               end
               1: begin
                  shape = FRAME_FILL;
                  level = 16'($urandom_range(0, 2000));
               end
               2: begin
                  shape = FRAME_SPARSE;
                  level = 16'($urandom_range(0, 65535));
               end
               default: begin
                  shape = FRAME_SPREAD;
                  level = 16'($urandom_range(0, 2000));
               end
            endcase
            send_frame(shape, level, restart_next, cut);
            // A broken frame is always followed by a restart; add a few clean ones.
            restart_next = (cut != FRAME_BINS) || ($urandom_range(99) < 3);
         end
         phase++;
      end
      calm = 1'b0;

      settle();
      if (mismatch_count == 0)
         $display("tb_weighted_histogram_intersection_keyframe: clean");
      else
         $display("tb_weighted_histogram_intersection_keyframe: errors");
      $finish;
   end

   // Result side: random back-pressure, plus one long hold-off on request
   // while the sender keeps going, so the result queue fills and req stalls.
   initial begin : receiver
      int hold_left;
      hold_left  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // Count rsp beats and end the run when neither channel moves for too long.
   initial begin : watchdog
      quiet_cycles = 0;
      results_seen = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) results_seen++;
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_weighted_histogram_intersection_keyframe: errors");
            $finish;
         end
      end
   end

endmodule

/* files.f */
sv/whik_pkg.sv
sv/whik_bin_store.sv
sv/whik_score.sv
sv/whik_out_queue.sv
sv/weighted_histogram_intersection_keyframe.sv
tb/whik_keyframe_checker.sv
tb/tb_weighted_histogram_intersection_keyframe.sv
